### rtl/ppv_pkg.sv
package ppv_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int RANGE_W = 23;
    localparam int OFS_W   = 24;
    localparam int SPD_W   = 24;
    localparam int CFG_W   = 23;
    localparam int BAND_W  = 18;
    localparam int CASE_W  = 3;
    localparam int IDX_W   = 3;

    localparam int Q_MAG     = 23;
    localparam int Q_GAMMA   = 31;
    localparam int DEN_W     = 46;
    localparam int CNT_W     = $clog2(Q_GAMMA + 1);
    localparam int MUL_A_W   = 31;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int NUM_W_DEF = 56;

    localparam logic [63:0] PI_Q29 = 64'd1686629713;

    localparam logic [CFG_W-1:0]  TARGET_DISTANCE_RST  = 23'd65536;
    localparam logic [CFG_W-1:0]  CLOSEST_DISTANCE_RST = 23'd32768;
    localparam logic [CFG_W-1:0]  SPEED_MAX_RST        = 23'd32768;
    localparam logic [CFG_W-1:0]  SPEED_MIN_RST        = 23'd6554;
    localparam logic [CFG_W-1:0]  TURN_RATE_MAX_RST    = 23'd65536;
    localparam logic [BAND_W-1:0] FORWARD_DEADBAND_RST = 18'd2287;
    localparam logic [BAND_W-1:0] REVERSE_DEADBAND_RST = 18'd5719;

    localparam logic [IDX_W-1:0] REG_TARGET_DISTANCE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CLOSEST_DISTANCE = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_MAX        = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_MIN        = 3'd3;
    localparam logic [IDX_W-1:0] REG_TURN_RATE_MAX    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FORWARD_DEADBAND = 3'd5;
    localparam logic [IDX_W-1:0] REG_REVERSE_DEADBAND = 3'd6;

    localparam logic [CASE_W-1:0] CASE_HOLD         = 3'd0;
    localparam logic [CASE_W-1:0] CASE_STOP         = 3'd1;
    localparam logic [CASE_W-1:0] CASE_FWD_STRAIGHT = 3'd2;
    localparam logic [CASE_W-1:0] CASE_FWD_RIGHT    = 3'd3;
    localparam logic [CASE_W-1:0] CASE_FWD_LEFT     = 3'd4;
    localparam logic [CASE_W-1:0] CASE_REV_STRAIGHT = 3'd5;
    localparam logic [CASE_W-1:0] CASE_REV_POS      = 3'd6;
    localparam logic [CASE_W-1:0] CASE_REV_NEG      = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_OFS,
        ST_MUL_DEN,
        ST_DIV_OFS,
        ST_GAM_START,
        ST_DIV_GAM,
        ST_DECIDE,
        ST_MUL_ANG,
        ST_FINISH
    } ppv_state_t;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

endpackage

### rtl/pure_pursuit_velocity.sv
// Pure-pursuit velocity command: one word in, one word out.
// The bit-serial divider runs 23 and 31 steps for the two quotients, and a quotient that
// saturates skips its run. The result waits while the output register is full; a new word
// is taken only once the previous result has entered the output register.
// Synchronous active-low reset restores the register defaults and zeroes the held speeds.
module pure_pursuit_velocity import ppv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // target_range [22:0], lateral_offset [46:23], bearing_error [70:47], zero [71]
    input  logic [71:0]       s_axis_tdata,
    // tracker_locked [0]
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // linear_speed [23:0], angular_speed [47:24]
    output logic [47:0]       m_axis_tdata,
    // case_taken [2:0]
    output logic [CASE_W-1:0] m_axis_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int NUM_W = (DEN_W > 24 + 2 * FRAC_BITS) ? DEN_W : 24 + 2 * FRAC_BITS;
    localparam logic [63:0] PI_FULL =
        (PI_Q29 + (64'd1 << (28 - FRAC_BITS))) >> (29 - FRAC_BITS);
    localparam logic signed [OFS_W-1:0] PI_Q = OFS_W'(PI_FULL);

    ppv_state_t state_reg, state_next;

    logic [CFG_W-1:0]  td_reg, td_next, cd_reg, cd_next;
    logic [CFG_W-1:0]  vmax_reg, vmax_next, vmin_reg, vmin_next, wmax_reg, wmax_next;
    logic [BAND_W-1:0] fd_reg, fd_next, rd_reg, rd_next;
    logic signed [SPD_W-1:0] held_lin_reg, held_lin_next, held_ang_reg, held_ang_next;
    logic              mvalid_reg, mvalid_next;

    logic [RANGE_W-1:0]      range_reg, range_next;
    logic signed [OFS_W-1:0] x_reg, x_next, bear_reg, bear_next;
    logic                    locked_reg, locked_next;
    logic signed [OFS_W-1:0] gr_reg, gr_next;
    logic [RANGE_W-1:0]      agr_reg, agr_next;
    logic [OFS_W-1:0]        ax_reg, ax_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [Q_MAG-1:0]        agx_reg, agx_next;
    logic [Q_GAMMA-1:0]      gamma_reg, gamma_next;
    logic [CASE_W-1:0]       kase_reg, kase_next;
    logic signed [SPD_W-1:0] lin_reg, lin_next;
    logic signed [SPD_W-1:0] olin_reg, olin_next, oang_reg, oang_next;
    logic [CASE_W-1:0]       ocase_reg, ocase_next;

    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               div_start, div_long, div_done;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [Q_GAMMA-1:0] div_quo;

    logic signed [25:0]      gr_w, fwd_pre, rev_pre, fwd_lin, rev_lin;
    logic signed [25:0]      vmax_w, vmin_w;
    logic signed [OFS_W-1:0] db_s;
    logic                    stop_band, fwd_go, in_band, pos_turn, neg_turn;
    logic [CASE_W-1:0]       kase_d;
    logic signed [SPD_W-1:0] lin_d;
    logic [SPD_W-1:0]        alin;
    logic [PROD_W-1:0]       p_scaled;
    logic [CFG_W-1:0]        ang_mag;
    logic signed [SPD_W-1:0] ang_turn, ang_d;
    logic                    out_free;

    ppv_div #(
        .NUM_W(NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .long_q   (div_long),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {oang_reg, olin_reg};
    assign m_axis_tuser  = ocase_reg;
    assign out_free      = !mvalid_reg || m_axis_tready;

    // Case selection on the latched word.
    assign gr_w      = 26'(gr_reg);
    assign vmax_w    = $signed({3'b000, vmax_reg});
    assign vmin_w    = $signed({3'b000, vmin_reg});
    assign stop_band = (range_reg <= td_reg) && (range_reg > cd_reg);
    assign fwd_go    = !gr_reg[OFS_W-1] && locked_reg;
    assign db_s      = fwd_go ? $signed({6'b000000, fd_reg}) : $signed({6'b000000, rd_reg});
    assign in_band   = (bear_reg >= -db_s) && (bear_reg <= db_s);
    assign pos_turn  = (bear_reg > db_s) && (bear_reg <= PI_Q);
    assign neg_turn  = (bear_reg < -db_s) && (bear_reg >= -PI_Q);
    assign fwd_pre   = in_band ? ((gr_w + (gr_w <<< 1)) >>> 1) : gr_w;
    assign rev_pre   = gr_w <<< 1;
    assign fwd_lin   = (fwd_pre > vmax_w) ? vmax_w : ((fwd_pre < vmin_w) ? vmin_w : fwd_pre);
    assign rev_lin   = (rev_pre < -vmax_w) ? -vmax_w :
                       ((rev_pre > -vmin_w) ? -vmin_w : rev_pre);

    always_comb begin
        if (stop_band) begin
            kase_d = locked_reg ? CASE_STOP : CASE_HOLD;
        end else if (fwd_go) begin
            kase_d = in_band ? CASE_FWD_STRAIGHT : pos_turn ? CASE_FWD_RIGHT :
                     neg_turn ? CASE_FWD_LEFT : CASE_HOLD;
        end else begin
            kase_d = in_band ? CASE_REV_STRAIGHT : pos_turn ? CASE_REV_POS :
                     neg_turn ? CASE_REV_NEG : CASE_HOLD;
        end
        if (kase_d == CASE_HOLD) begin
            lin_d = held_lin_reg;
        end else if (kase_d == CASE_STOP) begin
            lin_d = '0;
        end else begin
            lin_d = fwd_go ? SPD_W'(fwd_lin) : SPD_W'(rev_lin);
        end
    end

    // Angular speed from the curvature product, clamped on its live side.
    assign alin     = lin_reg[SPD_W-1] ? SPD_W'(-lin_reg) : SPD_W'(lin_reg);
    assign p_scaled = prod_reg >> FRAC_BITS;
    assign ang_mag  = (p_scaled > PROD_W'(wmax_reg)) ? wmax_reg : p_scaled[CFG_W-1:0];
    assign ang_turn = ((kase_reg == CASE_FWD_RIGHT) || (kase_reg == CASE_REV_POS))
                      ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});

    always_comb begin
        case (kase_reg)
            CASE_HOLD:      ang_d = held_ang_reg;
            CASE_FWD_RIGHT: ang_d = ang_turn;
            CASE_FWD_LEFT:  ang_d = ang_turn;
            CASE_REV_POS:   ang_d = ang_turn;
            CASE_REV_NEG:   ang_d = ang_turn;
            default:        ang_d = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        td_next       = td_reg;
        cd_next       = cd_reg;
        vmax_next     = vmax_reg;
        vmin_next     = vmin_reg;
        wmax_next     = wmax_reg;
        fd_next       = fd_reg;
        rd_next       = rd_reg;
        held_lin_next = held_lin_reg;
        held_ang_next = held_ang_reg;
        mvalid_next   = mvalid_reg && !m_axis_tready;
        range_next    = range_reg;
        x_next        = x_reg;
        bear_next     = bear_reg;
        locked_next   = locked_reg;
        gr_next       = gr_reg;
        agr_next      = agr_reg;
        ax_next       = ax_reg;
        agx_next      = agx_reg;
        gamma_next    = gamma_reg;
        kase_next     = kase_reg;
        lin_next      = lin_reg;
        olin_next     = olin_reg;
        oang_next     = oang_reg;
        ocase_next    = ocase_reg;
        mul_en        = 1'b0;
        mul_a         = MUL_A_W'(agr_reg);
        mul_b         = ax_reg;
        div_start     = 1'b0;
        div_long      = 1'b0;
        div_num       = NUM_W'(prod_reg[DEN_W-1:0]);
        div_den       = DEN_W'(range_reg);

        if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET_DISTANCE:  td_next   = cfg_data;
                REG_CLOSEST_DISTANCE: cd_next   = cfg_data;
                REG_SPEED_MAX:        vmax_next = cfg_data;
                REG_SPEED_MIN:        vmin_next = cfg_data;
                REG_TURN_RATE_MAX:    wmax_next = cfg_data;
                REG_FORWARD_DEADBAND: fd_next   = cfg_data[BAND_W-1:0];
                REG_REVERSE_DEADBAND: rd_next   = cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    range_next  = s_axis_tdata[22:0];
                    x_next      = $signed(s_axis_tdata[46:23]);
                    bear_next   = $signed(s_axis_tdata[70:47]);
                    locked_next = s_axis_tuser;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                gr_next    = $signed({1'b0, range_reg}) - $signed({1'b0, td_reg});
                agr_next   = range_reg >= td_reg ? range_reg - td_reg : td_reg - range_reg;
                ax_next    = x_reg[OFS_W-1] ? OFS_W'(-x_reg) : OFS_W'(x_reg);
                state_next = ST_MUL_OFS;
            end
            ST_MUL_OFS: begin
                mul_en     = 1'b1;
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                mul_en     = 1'b1;
                mul_b      = MUL_B_W'(agr_reg);
                div_start  = 1'b1;
                state_next = ST_DIV_OFS;
            end
            ST_DIV_OFS: begin
                if (div_done) begin
                    agx_next   = div_quo[Q_MAG-1:0];
                    state_next = ST_GAM_START;
                end
            end
            ST_GAM_START: begin
                div_start  = 1'b1;
                div_long   = 1'b1;
                div_num    = NUM_W'({agx_reg, 1'b0}) << (2 * FRAC_BITS);
                div_den    = prod_reg[DEN_W-1:0];
                state_next = ST_DIV_GAM;
            end
            ST_DIV_GAM: begin
                if (div_done) begin
                    gamma_next = div_quo;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                kase_next  = kase_d;
                lin_next   = lin_d;
                state_next = ST_MUL_ANG;
            end
            ST_MUL_ANG: begin
                mul_en     = 1'b1;
                mul_a      = gamma_reg;
                mul_b      = alin;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    olin_next     = lin_reg;
                    oang_next     = ang_d;
                    ocase_next    = kase_reg;
                    held_lin_next = lin_reg;
                    held_ang_next = ang_d;
                    mvalid_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        prod_next = mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            td_reg       <= TARGET_DISTANCE_RST;
            cd_reg       <= CLOSEST_DISTANCE_RST;
            vmax_reg     <= SPEED_MAX_RST;
            vmin_reg     <= SPEED_MIN_RST;
            wmax_reg     <= TURN_RATE_MAX_RST;
            fd_reg       <= FORWARD_DEADBAND_RST;
            rd_reg       <= REVERSE_DEADBAND_RST;
            held_lin_reg <= '0;
            held_ang_reg <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            td_reg       <= td_next;
            cd_reg       <= cd_next;
            vmax_reg     <= vmax_next;
            vmin_reg     <= vmin_next;
            wmax_reg     <= wmax_next;
            fd_reg       <= fd_next;
            rd_reg       <= rd_next;
            held_lin_reg <= held_lin_next;
            held_ang_reg <= held_ang_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        range_reg  <= range_next;
        x_reg      <= x_next;
        bear_reg   <= bear_next;
        locked_reg <= locked_next;
        gr_reg     <= gr_next;
        agr_reg    <= agr_next;
        ax_reg     <= ax_next;
        prod_reg   <= prod_next;
        agx_reg    <= agx_next;
        gamma_reg  <= gamma_next;
        kase_reg   <= kase_next;
        lin_reg    <= lin_next;
        olin_reg   <= olin_next;
        oang_reg   <= oang_next;
        ocase_reg  <= ocase_next;
    end

endmodule

### rtl/ppv_div.sv
module ppv_div import ppv_pkg::*; #(
    parameter int NUM_W = NUM_W_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               long_q,
    input  logic [NUM_W-1:0]   dividend,
    input  logic [DEN_W-1:0]   divisor,
    output logic               done,
    output logic [Q_GAMMA-1:0] quotient
);

    div_state_t         state_reg, state_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   dvs_reg, dvs_next;
    logic [NUM_W-1:0]   lo_reg, lo_next;
    logic [Q_GAMMA-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [NUM_W-1:0]   hi;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    assign hi    = long_q ? (dividend >> Q_GAMMA) : (dividend >> Q_MAG);
    assign trial = {rem_reg, lo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    dvs_next = divisor;
                    // A quotient that would not fit, and a zero divisor, saturate.
                    if (hi >= NUM_W'(divisor)) begin
                        quo_next  = long_q ? {Q_GAMMA{1'b1}}
                                           : Q_GAMMA'((64'd1 << Q_MAG) - 64'd1);
                        done_next = 1'b1;
                    end else begin
                        rem_next   = hi[DEN_W-1:0];
                        lo_next    = long_q ? (dividend << (NUM_W - Q_GAMMA))
                                            : (dividend << (NUM_W - Q_MAG));
                        cnt_next   = long_q ? CNT_W'(Q_GAMMA) : CNT_W'(Q_MAG);
                        quo_next   = '0;
                        state_next = DIV_RUN;
                    end
                end
            end
            DIV_RUN: begin
                rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next = {quo_reg[Q_GAMMA-2:0], fits};
                lo_next  = lo_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = DIV_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### tb/sv/pure_pursuit_velocity_test.sv
`timescale 1ns / 100ps

module pure_pursuit_velocity_test import ppv_pkg::*;;

    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int RANGE_MAX      = 8388607;
    localparam int BAND_MAX       = 205887;
    localparam longint MAG_SAT    = 64'h7F_FFFF;
    localparam longint GAMMA_SAT  = 64'h7FFF_FFFF;
    localparam longint PI_Q       = (PI_Q29 + (64'd1 << (28 - FRAC))) >> (29 - FRAC);
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 110;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [RANGE_W-1:0] tgt_range;
        logic [OFS_W-1:0]   lat_ofs;
        logic [OFS_W-1:0]   bearing;
        logic               locked;
    } target_t;

    typedef struct packed {
        logic [SPD_W-1:0]  lin;
        logic [SPD_W-1:0]  ang;
        logic [CASE_W-1:0] kind;
    } command_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;
    logic [CASE_W-1:0] m_axis_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    logic [CFG_W-1:0]  lim_target   = TARGET_DISTANCE_RST;
    logic [CFG_W-1:0]  lim_closest  = CLOSEST_DISTANCE_RST;
    logic [CFG_W-1:0]  lim_vmax     = SPEED_MAX_RST;
    logic [CFG_W-1:0]  lim_vmin     = SPEED_MIN_RST;
    logic [CFG_W-1:0]  lim_wmax     = TURN_RATE_MAX_RST;
    logic [BAND_W-1:0] lim_fwd_band = FORWARD_DEADBAND_RST;
    logic [BAND_W-1:0] lim_rev_band = REVERSE_DEADBAND_RST;
    longint            held_lin = 0;
    longint            held_ang = 0;

    target_t     pending_targets[$];
    command_t    expected_cmds[$];
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit          steady_feed = 1'b0;
    bit          hold_arm = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          fail_count = 0;
    int          targets_sent = 0;
    int          commands_checked = 0;
    int          case_hits[8] = '{default: 0};

    pure_pursuit_velocity DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint curve_rate(longint unsigned gamma, longint lin);
        longint p;
        p = (gamma * magnitude(lin)) >> FRAC;
        return (lin < 0) ? -p : p;
    endfunction

    function automatic command_t steer_command(target_t t);
        longint rng, x, brg, td, cd, vmax, vmin, wmax, gr, lin, ang, v, band;
        longint unsigned agx, gamma, den;
        logic [CASE_W-1:0] kind;
        command_t c;
        rng = t.tgt_range;
        x = $signed(t.lat_ofs);
        brg = $signed(t.bearing);
        td = lim_target;
        cd = lim_closest;
        vmax = lim_vmax;
        vmin = lim_vmin;
        wmax = lim_wmax;
        gr = rng - td;
        lin = held_lin;
        ang = held_ang;
        kind = CASE_HOLD;

        if (rng == 0) begin
            agx = MAG_SAT;
        end else begin
            agx = (magnitude(gr) * magnitude(x)) / magnitude(rng);
            if (agx > MAG_SAT) agx = MAG_SAT;
        end
        den = magnitude(gr) * magnitude(gr);
        if (den == 0) begin
            gamma = GAMMA_SAT;
        end else begin
            gamma = ((agx << 1) << (2 * FRAC)) / den;
            if (gamma > GAMMA_SAT) gamma = GAMMA_SAT;
        end

        if (rng <= td && rng > cd) begin
            if (t.locked) begin
                lin = 0;
                ang = 0;
                kind = CASE_STOP;
            end
        end else if (gr >= 0 && t.locked) begin
            band = lim_fwd_band;
            v = gr;
            if (v > vmax) v = vmax;
            else if (v < vmin) v = vmin;
            if (-band <= brg && brg <= band) begin
                lin = (3 * gr) >>> 1;
                if (lin > vmax) lin = vmax;
                else if (lin < vmin) lin = vmin;
                ang = 0;
                kind = CASE_FWD_STRAIGHT;
            end else if (brg > band && brg <= PI_Q) begin
                lin = v;
                ang = -curve_rate(gamma, v);
                if (ang < -wmax) ang = -wmax;
                kind = CASE_FWD_RIGHT;
            end else if (brg < -band && brg >= -PI_Q) begin
                lin = v;
                ang = curve_rate(gamma, v);
                if (ang > wmax) ang = wmax;
                kind = CASE_FWD_LEFT;
            end
        end else begin
            band = lim_rev_band;
            v = 2 * gr;
            if (v < -vmax) v = -vmax;
            else if (v > -vmin) v = -vmin;
            if (-band <= brg && brg <= band) begin
                lin = v;
                ang = 0;
                kind = CASE_REV_STRAIGHT;
            end else if (brg > band && brg <= PI_Q) begin
                lin = v;
                ang = curve_rate(gamma, v);
                if (ang < -wmax) ang = -wmax;
                kind = CASE_REV_POS;
            end else if (brg < -band && brg >= -PI_Q) begin
                lin = v;
                ang = -curve_rate(gamma, v);
                if (ang > wmax) ang = wmax;
                kind = CASE_REV_NEG;
            end
        end

        held_lin = lin;
        held_ang = ang;
        c.lin = lin[SPD_W-1:0];
        c.ang = ang[SPD_W-1:0];
        c.kind = kind;
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_feed) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        longint r;
        case ($urandom_range(0, 5))
            0: r = $urandom_range(0, RANGE_MAX);
            1: r = longint'(lim_target) + $urandom_range(0, 8) - 4;
            2: r = longint'(lim_closest) + $urandom_range(0, 8) - 4;
            3: r = $urandom_range(0, 1023);
            4: r = longint'(lim_target) + $urandom_range(0, 400000) - 200000;
            default: r = longint'(lim_closest) + $urandom_range(0, 400000) - 200000;
        endcase
        if (r < 0) r = 0;
        if (r > RANGE_MAX) r = RANGE_MAX;
        return r[RANGE_W-1:0];
    endfunction

    function automatic logic [OFS_W-1:0] pick_offset();
        logic [OFS_W-1:0] raw;
        longint o;
        raw = $urandom;
        case ($urandom_range(0, 3))
            0, 1: o = $signed(raw);
            2: o = longint'($urandom_range(0, 140000)) - 70000;
            default: o = $urandom_range(0, 1) ? -8388608 : 8388607;
        endcase
        return o[OFS_W-1:0];
    endfunction

    function automatic logic [OFS_W-1:0] pick_bearing();
        logic [OFS_W-1:0] raw;
        longint b, band;
        raw = $urandom;
        band = $urandom_range(0, 1) ? lim_fwd_band : lim_rev_band;
        case ($urandom_range(0, 5))
            0: b = $signed(raw);
            1: b = longint'($urandom_range(0, 2 * band)) - band;
            2: b = band + $urandom_range(0, 2) - 1;
            3: b = PI_Q + $urandom_range(0, 2) - 1;
            4: b = longint'($urandom_range(0, 600000)) - 300000;
            default: b = longint'($urandom_range(0, 64)) - 32;
        endcase
        if ($urandom_range(0, 1)) b = -b;
        return b[OFS_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        return $urandom_range(0, 1) ? CFG_W'($urandom_range(0, RANGE_MAX))
                                    : CFG_W'($urandom_range(0, 300000));
    endfunction

    task automatic add_target(input longint rng, input longint ofs,
                              input longint brg, input logic locked);
        target_t t;
        t.tgt_range = rng[RANGE_W-1:0];
        t.lat_ofs = ofs[OFS_W-1:0];
        t.bearing = brg[OFS_W-1:0];
        t.locked = locked;
        pending_targets.push_back(t);
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (pending_targets.size() != 0 || expected_cmds.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input longint value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_DISTANCE:  lim_target = value[CFG_W-1:0];
            REG_CLOSEST_DISTANCE: lim_closest = value[CFG_W-1:0];
            REG_SPEED_MAX:        lim_vmax = value[CFG_W-1:0];
            REG_SPEED_MIN:        lim_vmin = value[CFG_W-1:0];
            REG_TURN_RATE_MAX:    lim_wmax = value[CFG_W-1:0];
            REG_FORWARD_DEADBAND: lim_fwd_band = value[BAND_W-1:0];
            REG_REVERSE_DEADBAND: lim_rev_band = value[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int phase);
        case (phase)
            1: begin
                write_reg(REG_TARGET_DISTANCE, 0);
                write_reg(REG_CLOSEST_DISTANCE, 0);
                write_reg(REG_SPEED_MAX, RANGE_MAX);
                write_reg(REG_SPEED_MIN, 0);
                write_reg(REG_TURN_RATE_MAX, RANGE_MAX);
                write_reg(REG_FORWARD_DEADBAND, 0);
                write_reg(REG_REVERSE_DEADBAND, 0);
            end
            2: begin
                write_reg(REG_TARGET_DISTANCE, RANGE_MAX);
                write_reg(REG_CLOSEST_DISTANCE, RANGE_MAX);
                write_reg(REG_SPEED_MAX, 0);
                write_reg(REG_SPEED_MIN, 0);
                write_reg(REG_TURN_RATE_MAX, 0);
                write_reg(REG_FORWARD_DEADBAND, BAND_MAX);
                write_reg(REG_REVERSE_DEADBAND, BAND_MAX);
            end
            3: begin
                write_reg(REG_TARGET_DISTANCE, 131072);
                write_reg(REG_CLOSEST_DISTANCE, 262144);
                write_reg(REG_SPEED_MAX, 100000);
                write_reg(REG_SPEED_MIN, 300000);
                write_reg(REG_TURN_RATE_MAX, 1000);
                write_reg(REG_FORWARD_DEADBAND, 23'h7C0000 | 23'd1500);
                write_reg(REG_REVERSE_DEADBAND, 23'h7C0000 | 23'd9000);
            end
            default: begin
                write_reg(REG_TARGET_DISTANCE, pick_limit());
                write_reg(REG_CLOSEST_DISTANCE, pick_limit());
                write_reg(REG_SPEED_MAX, pick_limit());
                write_reg(REG_SPEED_MIN, pick_limit());
                write_reg(REG_TURN_RATE_MAX, pick_limit());
                write_reg(REG_FORWARD_DEADBAND, $urandom_range(0, BAND_MAX));
                write_reg(REG_REVERSE_DEADBAND, $urandom_range(0, BAND_MAX));
            end
        endcase
    endtask

    always @(posedge aclk) begin : feed
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_cmds.push_back(steer_command(pending_targets.pop_front()));
                targets_sent++;
                send_gap = pick_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_targets.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, pending_targets[0].bearing,
                                     pending_targets[0].lat_ofs, pending_targets[0].tgt_range};
                    s_axis_tuser <= pending_targets[0].locked;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : backpressure
        if (!aresetn) begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : sink
        command_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.lin = m_axis_tdata[SPD_W-1:0];
                got.ang = m_axis_tdata[2*SPD_W-1:SPD_W];
                got.kind = m_axis_tuser;
                recv_gap = pick_gap();
                if (expected_cmds.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected word: lin %0d ang %0d case %0d",
                                 $signed(got.lin), $signed(got.ang), got.kind);
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    commands_checked++;
                    case_hits[want.kind]++;
                    if (got.lin !== want.lin || got.ang !== want.ang || got.kind !== want.kind)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch on word %0d: expected lin %0d ang %0d case %0d, %s",
                                     commands_checked, $signed(want.lin), $signed(want.ang),
                                     want.kind, $sformatf("got lin %0d ang %0d case %0d",
                                     $signed(got.lin), $signed(got.ang), got.kind));
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                wait_idle();
                set_limits(phase);
            end
            @(negedge aclk);
            steady_feed = (phase % 3 == 2);
            if (phase == 3) hold_arm = ~hold_arm;
            if (phase == 0) begin
                add_target(50000, 1000, 0, 1'b1);
                add_target(50000, 1000, 0, 1'b0);
                add_target(200000, 20000, 0, 1'b1);
                add_target(200000, 20000, 0, 1'b0);
                add_target(200000, 20000, 100000, 1'b1);
                add_target(200000, -20000, -100000, 1'b1);
                add_target(200000, 20000, PI_Q, 1'b1);
                add_target(200000, 20000, -PI_Q, 1'b1);
                add_target(200000, 20000, PI_Q + 1, 1'b1);
                add_target(200000, 20000, -PI_Q - 1, 1'b1);
                add_target(10000, 5000, 0, 1'b1);
                add_target(10000, 5000, 50000, 1'b1);
                add_target(10000, 5000, -50000, 1'b1);
                add_target(0, 0, 0, 1'b1);
                add_target(0, 8388607, 30000, 1'b1);
                add_target(RANGE_MAX, 8388607, 8388607, 1'b1);
                add_target(RANGE_MAX, -8388608, 2288, 1'b1);
                add_target(RANGE_MAX, 8388607, -2288, 1'b1);
                add_target(RANGE_MAX, 0, 2287, 1'b1);
                add_target(RANGE_MAX, -8388608, -8388608, 1'b0);
                add_target(32768, 100, 5719, 1'b1);
                add_target(32768, 100, -5720, 1'b0);
                add_target(65536, 100, 100000, 1'b1);
                add_target(65537, 1, -1, 1'b1);
                add_target(1, -1, 5720, 1'b1);
            end else if (phase == 1) begin
                add_target(0, 1000, 0, 1'b1);
                add_target(0, 1000, 100000, 1'b1);
                add_target(1, 5, 50000, 1'b1);
                add_target(0, 0, -50000, 1'b0);
            end
            repeat (PHASE_ITEMS)
                add_target(pick_range(), pick_offset(), pick_bearing(), $urandom_range(0, 9) != 0);
        end
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d targets and checked %0d commands over %0d register settings.",
                 targets_sent, commands_checked, PHASES);
        $display("Cases: hold %0d, stop %0d, fwd %0d/%0d/%0d, rev %0d/%0d/%0d",
                 case_hits[CASE_HOLD], case_hits[CASE_STOP], case_hits[CASE_FWD_STRAIGHT],
                 case_hits[CASE_FWD_RIGHT], case_hits[CASE_FWD_LEFT],
                 case_hits[CASE_REV_STRAIGHT], case_hits[CASE_REV_POS], case_hits[CASE_REV_NEG]);
        if (fail_count == 0 && expected_cmds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ppv_pkg.sv
rtl/ppv_div.sv
rtl/pure_pursuit_velocity.sv
tb/sv/pure_pursuit_velocity_test.sv
